// ----- hw/rtl/vdi_pkg.sv -----
// ---------------------------------------------------------------------------
// vdi_pkg
// Shared types and constants of the vertex deduplication indexer.
// ---------------------------------------------------------------------------
package vdi_pkg;

  // number of unique vertex entries, one cell each
  localparam int CAPACITY = 1024;

  // key word width and result field widths
  localparam int WORD_W = 32;
  localparam int VIDX_W = 10;
  localparam int UCNT_W = 11;

  // width of a cell position or a fill count (0 .. CAPACITY)
  localparam int POS_W = $clog2(CAPACITY + 1);

  // one 128-bit vertex key
  typedef struct packed {
    logic [WORD_W-1:0] w3;
    logic [WORD_W-1:0] w2;
    logic [WORD_W-1:0] w1;
    logic [WORD_W-1:0] w0;
  } vdi_key_t;

  // registered report of one cell to its neighbor and to the control
  typedef struct packed {
    logic act;  // search token moves on to the next cell
    logic hit;  // stored entry equals the key
    logic wr;   // key was stored as a new entry
  } vdi_cell_stat_t;

endpackage

// ----- hw/rtl/vdi_in_if.sv -----
// ---------------------------------------------------------------------------
// vdi_in_if
// Vertex key channel: one beat carries one 128-bit vertex key.
// ---------------------------------------------------------------------------
interface vdi_in_if;

  logic                      valid;
  logic                      ready;
  logic [vdi_pkg::WORD_W-1:0] key_word0;
  logic [vdi_pkg::WORD_W-1:0] key_word1;
  logic [vdi_pkg::WORD_W-1:0] key_word2;
  logic [vdi_pkg::WORD_W-1:0] key_word3;

  modport source (
    output valid, key_word0, key_word1, key_word2, key_word3,
    input  ready
  );

  modport sink (
    input  valid, key_word0, key_word1, key_word2, key_word3,
    output ready
  );

endinterface

// ----- hw/rtl/vdi_out_if.sv -----
// ---------------------------------------------------------------------------
// vdi_out_if
// Index channel: one beat carries one index-buffer entry and its status.
// ---------------------------------------------------------------------------
interface vdi_out_if;

  logic                       valid;
  logic                       ready;
  logic [vdi_pkg::VIDX_W-1:0] vertex_index;
  logic                       is_new;
  logic                       table_full;
  logic [vdi_pkg::UCNT_W-1:0] unique_count;

  modport source (
    output valid, vertex_index, is_new, table_full, unique_count,
    input  ready
  );

  modport sink (
    input  valid, vertex_index, is_new, table_full, unique_count,
    output ready
  );

endinterface

// ----- hw/rtl/vertex_dedup_indexer_unit.sv -----
// ---------------------------------------------------------------------------
// vertex_dedup_indexer_unit
// One key is in flight at a time: the search token steps one cell per cycle
// along the row of entry cells until it meets the matching entry or the
// first free cell, or runs off the end of a full table; the next key is
// taken in the cycle after the index beat is loaded.
// Reset empties the table (fill count to zero) and drops any pending beat.
// ---------------------------------------------------------------------------
module vertex_dedup_indexer_unit (
  input  logic      clk,
  input  logic      rst,
  vdi_in_if.sink    vtx_in,
  vdi_out_if.source idx_out
);

  logic                         busy;
  logic                         go;
  logic                         res_pend;
  logic [vdi_pkg::POS_W-1:0]    pos;
  logic [vdi_pkg::POS_W-1:0]    fill;
  vdi_pkg::vdi_key_t            key;

  logic [vdi_pkg::POS_W-1:0]    res_idx;
  logic                         res_new;
  logic                         res_full;

  logic                         out_valid;
  logic [vdi_pkg::VIDX_W-1:0]   out_idx;
  logic                         out_new;
  logic                         out_full;
  logic [vdi_pkg::UCNT_W-1:0]   out_cnt;

  vdi_pkg::vdi_cell_stat_t      stat [vdi_pkg::CAPACITY];
  logic [vdi_pkg::CAPACITY-1:0] hit_vec;
  logic [vdi_pkg::CAPACITY-1:0] wr_vec;
  logic                         in_fire;
  logic                         searching;
  logic                         any_hit;
  logic                         any_wr;
  logic                         off_end;
  logic                         out_free;
  logic [vdi_pkg::POS_W-1:0]    cur_idx;

  // handshake
  assign vtx_in.ready = !busy && !rst;
  assign in_fire      = vtx_in.valid && vtx_in.ready;
  assign searching    = busy && !res_pend;
  assign out_free     = !out_valid || idx_out.ready;

  // row of entry cells, token enters at the first one
  for (genvar i = 0; i < vdi_pkg::CAPACITY; i++) begin : g_cell
    logic act_in;
    if (i == 0) begin : g_head
      assign act_in = go;
    end else begin : g_body
      assign act_in = stat[i-1].act;
    end

    vdi_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_pos (vdi_pkg::POS_W'(i)),
      .fill     (fill),
      .key      (key),
      .act_in   (act_in),
      .stat     (stat[i])
    );

    assign hit_vec[i] = stat[i].hit;
    assign wr_vec[i]  = stat[i].wr;
  end

  // reports are registered and trail the token position by one cell
  assign any_hit = |hit_vec;
  assign any_wr  = |wr_vec;
  assign off_end = stat[vdi_pkg::CAPACITY-1].act;
  assign cur_idx = vdi_pkg::POS_W'(pos - 1'b1);

  // search control and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      go       <= 1'b0;
      res_pend <= 1'b0;
      fill     <= '0;
    end else begin
      go <= in_fire;
      if (in_fire) begin
        busy <= 1'b1;
      end
      if (searching && (any_hit || any_wr || off_end)) begin
        res_pend <= 1'b1;
        if (any_wr) begin
          fill <= vdi_pkg::POS_W'(fill + 1'b1);
        end
      end
      if (res_pend && out_free) begin
        res_pend <= 1'b0;
        busy     <= 1'b0;
      end
    end
  end

  // key capture, token position and held result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key.w0 <= vtx_in.key_word0;
      key.w1 <= vtx_in.key_word1;
      key.w2 <= vtx_in.key_word2;
      key.w3 <= vtx_in.key_word3;
      pos    <= '0;
    end else if (searching) begin
      pos <= vdi_pkg::POS_W'(pos + 1'b1);
    end
    if (searching && (any_hit || any_wr || off_end)) begin
      res_idx  <= (any_hit || any_wr) ? cur_idx : '0;
      res_new  <= any_wr;
      res_full <= !any_hit && !any_wr;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_pend && out_free) begin
      out_valid <= 1'b1;
    end else if (idx_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_pend && out_free) begin
      out_idx  <= vdi_pkg::VIDX_W'(res_idx);
      out_new  <= res_new;
      out_full <= res_full;
      out_cnt  <= vdi_pkg::UCNT_W'(fill);
    end
  end

  assign idx_out.valid        = out_valid;
  assign idx_out.vertex_index = out_idx;
  assign idx_out.is_new       = out_new;
  assign idx_out.table_full   = out_full;
  assign idx_out.unique_count = out_cnt;

endmodule

// ----- hw/rtl/vdi_cell.sv -----
// ---------------------------------------------------------------------------
// vdi_cell
// One entry of the vertex table: when the search token arrives, it stores
// the broadcast key if first free, else passes the token on if no match.
// ---------------------------------------------------------------------------
module vdi_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [vdi_pkg::POS_W-1:0]  cell_pos,
  input  logic [vdi_pkg::POS_W-1:0]  fill,
  input  vdi_pkg::vdi_key_t          key,
  input  logic                       act_in,
  output vdi_pkg::vdi_cell_stat_t    stat
);

  vdi_pkg::vdi_key_t entry;
  logic              at_end;
  logic              match;

  // first free cell and bitwise key compare
  assign at_end = (cell_pos == fill);
  assign match  = (entry == key);

  // stored key, written once when the cell is the first free one
  always_ff @(posedge clk) begin
    if (act_in && at_end) begin
      entry <= key;
    end
  end

  // token hand-off and report
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else begin
      stat.act <= act_in && !at_end && !match;
      stat.hit <= act_in && !at_end && match;
      stat.wr  <= act_in && at_end;
    end
  end

endmodule

// ----- tb/tb_vertex_dedup_indexer_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_vertex_dedup_indexer_unit
// Sends vertex keys into the dedup indexer and checks every index beat
// against a predicted table of unique vertices. A short directed table comes
// first, then random traffic fills the table to capacity and keeps going once
// it is full. The random part runs under several idle and stall patterns.
// ---------------------------------------------------------------------------
module tb_vertex_dedup_indexer_unit;

  localparam int RAND_ITEMS   = 1200;
  localparam int FULL_ITEMS   = 120;
  localparam int PHASE_LEN    = 300;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 32;
  localparam int LIMIT_CYCLES = 5_000_000;
  localparam int DIR_N        = 21;

  // one index-buffer entry as seen on the output channel
  typedef struct packed {
    logic [vdi_pkg::VIDX_W-1:0] vertex_index;
    logic                       is_new;
    logic                       table_full;
    logic [vdi_pkg::UCNT_W-1:0] unique_count;
  } index_entry_t;

  // directed row: key plus an optional hand-written index entry
  typedef struct packed {
    vdi_pkg::vdi_key_t key;
    logic              typed;
    index_entry_t      want;
  } dir_row_t;

  logic clk;
  logic rst;

  vdi_in_if  vtx_in();
  vdi_out_if idx_out();

  vertex_dedup_indexer_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .vtx_in (vtx_in),
    .idx_out(idx_out)
  );

  // predicted table of unique vertices, in order of insertion
  vdi_pkg::vdi_key_t seen_keys[$];
  int unsigned       slot_of[logic [4*vdi_pkg::WORD_W-1:0]];
  // index entries still owed by the block
  index_entry_t      want_q[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;
  int hold_seen;
  int hold_left;
  int err_cnt;
  int cycle_cnt;
  int n_new;
  int n_hit;
  int n_full;

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // predicted index entry for one key; updates the table
  function automatic index_entry_t dedup_lookup(input vdi_pkg::vdi_key_t key);
    index_entry_t                 r;
    logic [4*vdi_pkg::WORD_W-1:0] k;
    k = key;
    r = '0;
    if (slot_of.exists(k)) begin
      r.vertex_index = vdi_pkg::VIDX_W'(slot_of[k]);
    end else if (seen_keys.size() < vdi_pkg::CAPACITY) begin
      r.vertex_index = vdi_pkg::VIDX_W'(seen_keys.size());
      r.is_new       = 1'b1;
      slot_of[k]     = seen_keys.size();
      seen_keys      = {seen_keys, key};
    end else begin
      r.table_full = 1'b1;
    end
    r.unique_count = vdi_pkg::UCNT_W'(seen_keys.size());
    return r;
  endfunction

  // stored key, mostly from the low entries to keep searches short
  function automatic vdi_pkg::vdi_key_t pick_stored_key();
    int unsigned n;
    int unsigned top;
    int unsigned i;
    n   = seen_keys.size();
    top = (n < 32) ? n - 1 : 31;
    case ($urandom_range(9))
      0:       i = $urandom_range(n - 1, 0);
      1:       i = n - 1;
      default: i = $urandom_range(top, 0);
    endcase
    return seen_keys[i];
  endfunction

  // float-looking word: zeros, ones, infinities, nan, or raw bits
  function automatic logic [vdi_pkg::WORD_W-1:0] float_word();
    case ($urandom_range(13))
      0:       return 32'h0000_0000;
      1:       return 32'h8000_0000;
      2:       return 32'h3F80_0000;
      3:       return 32'hBF80_0000;
      4:       return 32'h7FC0_0000;
      5:       return 32'h7F80_0000;
      6:       return 32'hFF80_0000;
      default: return $urandom();
    endcase
  endfunction

  // key that is most likely not in the table yet
  function automatic vdi_pkg::vdi_key_t make_fresh_key();
    logic [4*vdi_pkg::WORD_W-1:0] bits;
    vdi_pkg::vdi_key_t            k;
    int unsigned                  b;
    k = {$urandom(), $urandom(), $urandom(), $urandom()};
    case ($urandom_range(9))
      0, 1, 2: begin
        // near miss: one bit away from a stored vertex
        if (seen_keys.size() != 0) begin
          bits    = pick_stored_key();
          b       = $urandom_range(4 * vdi_pkg::WORD_W - 1);
          bits[b] = ~bits[b];
          k       = bits;
        end
      end
      3, 4: begin
        k.w0 = float_word();
        k.w1 = float_word();
        k.w2 = float_word();
        k.w3 = ($urandom_range(1) != 0) ? '0 : $urandom();
      end
      default: ;
    endcase
    return k;
  endfunction

  // offer one key beat, record its index entry once taken
  task automatic send_key(input vdi_pkg::vdi_key_t key, input logic typed,
                          input index_entry_t want);
    index_entry_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      vtx_in.valid <= 1'b0;
      @(posedge clk);
    end
    vtx_in.valid     <= 1'b1;
    vtx_in.key_word0 <= key.w0;
    vtx_in.key_word1 <= key.w1;
    vtx_in.key_word2 <= key.w2;
    vtx_in.key_word3 <= key.w3;
    do @(posedge clk); while (!vtx_in.ready);
    predicted = dedup_lookup(key);
    want_q    = {want_q, (typed ? want : predicted)};
  endtask

  // drop valid and wait until every index beat has arrived
  task automatic wait_idle();
    vtx_in.valid <= 1'b0;
    do @(posedge clk); while (want_q.size() != 0);
  endtask

  // index beat check and ready generation
  always @(posedge clk) begin : idx_sink
    index_entry_t w;
    if (!rst && idx_out.valid && idx_out.ready) begin
      if (want_q.size() == 0) begin
        $display("%0t: index beat with nothing expected: index %0d new %0b full %0b count %0d",
                 $time, idx_out.vertex_index, idx_out.is_new, idx_out.table_full,
                 idx_out.unique_count);
        err_cnt++;
      end else begin
        w = want_q.pop_front();
        if (idx_out.vertex_index !== w.vertex_index) begin
          $display("%0t: vertex_index expected %0d got %0d",
                   $time, w.vertex_index, idx_out.vertex_index);
          err_cnt++;
        end
        if (idx_out.is_new !== w.is_new) begin
          $display("%0t: is_new expected %0b got %0b", $time, w.is_new, idx_out.is_new);
          err_cnt++;
        end
        if (idx_out.table_full !== w.table_full) begin
          $display("%0t: table_full expected %0b got %0b",
                   $time, w.table_full, idx_out.table_full);
          err_cnt++;
        end
        if (idx_out.unique_count !== w.unique_count) begin
          $display("%0t: unique_count expected %0d got %0d",
                   $time, w.unique_count, idx_out.unique_count);
          err_cnt++;
        end
        if (w.is_new) n_new++;
        else if (w.table_full) n_full++;
        else n_hit++;
      end
    end
    // long hold on request, else random stalls
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      idx_out.ready <= 1'b0;
    end else begin
      idx_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("vertex_dedup_indexer_unit test failed");
      $finish;
    end
  end

  // stimulus
  initial begin : stim
    dir_row_t          dir_rows [DIR_N];
    vdi_pkg::vdi_key_t key;
    int                rand_done;
    int                full_done;
    int                phase;
    rst              = 1'b1;
    vtx_in.valid     <= 1'b0;
    vtx_in.key_word0 <= '0;
    vtx_in.key_word1 <= '0;
    vtx_in.key_word2 <= '0;
    vtx_in.key_word3 <= '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_req         = 0;

    // directed rows: key {w3, w2, w1, w0}, typed flag, entry
    dir_rows = '{
      '{128'h0, 1'b1, '{10'd0, 1'b1, 1'b0, 11'd1}},
      '{128'h0, 1'b1, '{10'd0, 1'b0, 1'b0, 11'd1}},
      '{{128{1'b1}}, 1'b1, '{10'd1, 1'b1, 1'b0, 11'd2}},
      '{128'h0000_0000_0000_0000_0000_0000_8000_0000, 1'b0, '0},
      '{128'h8000_0000_0000_0000_0000_0000_0000_0000, 1'b0, '0},
      '{128'h0000_0000_7FC0_0000_7FC0_0000_7FC0_0000, 1'b0, '0},
      '{128'h0000_0000_7FC0_0000_7FC0_0000_7FC0_0000, 1'b0, '0},
      '{128'h0000_0000_7FC0_0000_7FC0_0000_7FC0_0001, 1'b0, '0},
      '{128'h0000_0000_4040_0000_4000_0000_3F80_0000, 1'b0, '0},
      '{128'h0, 1'b1, '{10'd0, 1'b0, 1'b0, 11'd7}},
      '{128'h7FFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF, 1'b0, '0},
      '{128'h0000_0000_4040_0000_4000_0000_3F80_0000, 1'b0, '0},
      '{128'h0000_0000_0000_0000_0000_0001_0000_0000, 1'b0, '0},
      '{128'h0000_0000_0000_0001_0000_0000_0000_0000, 1'b0, '0},
      '{128'h0000_0001_0000_0000_0000_0000_0000_0000, 1'b0, '0},
      '{128'h0000_0000_0000_0000_0000_0000_0000_0001, 1'b0, '0},
      '{{128{1'b1}}, 1'b1, '{10'd1, 1'b0, 1'b0, 11'd12}},
      '{128'h5555_5555_AAAA_AAAA_5555_5555_AAAA_AAAA, 1'b0, '0},
      '{128'hAAAA_AAAA_5555_5555_AAAA_AAAA_5555_5555, 1'b0, '0},
      '{128'h0000_0000_0000_0000_8000_0000_0000_0000, 1'b0, '0},
      '{128'h0000_0000_0000_0000_0000_0000_8000_0000, 1'b0, '0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part, back to back
    for (int i = 0; i < DIR_N; i++) begin
      send_key(dir_rows[i].key, dir_rows[i].typed, dir_rows[i].want);
    end

    // random part: fill the table, then keep going while it is full
    rand_done = 0;
    full_done = 0;
    while (rand_done < RAND_ITEMS || full_done < FULL_ITEMS) begin
      phase = rand_done / PHASE_LEN;
      if (rand_done % PHASE_LEN == 0 && phase <= 3) begin
        wait_idle();
        case (phase)
          0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1:       begin send_idle_pct = 66; recv_stall_pct = 0;  end
          2:       begin send_idle_pct = 0;  recv_stall_pct = 66; end
          default: begin send_idle_pct = 12; recv_stall_pct = 12; end
        endcase
      end
      // receiver holds off while keys keep coming
      if (rand_done == 40) hold_req++;
      if (seen_keys.size() == vdi_pkg::CAPACITY) begin
        full_done++;
        key = ($urandom_range(9) < 7) ? pick_stored_key() : make_fresh_key();
      end else if (seen_keys.size() != 0 && $urandom_range(9) == 0) begin
        key = pick_stored_key();
      end else begin
        key = make_fresh_key();
      end
      send_key(key, 1'b0, '0);
      rand_done++;
    end

    recv_stall_pct = 0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d index beats: %0d appended, %0d matched, %0d dropped on a full table",
             n_new + n_hit + n_full, n_new, n_hit, n_full);
    $display("idle patterns: none, sender 66%%, receiver 66%%, both 12%%, one %0d-cycle hold",
             LONG_HOLD);
    if (err_cnt == 0) begin
      $display("vertex_dedup_indexer_unit test passed");
    end else begin
      $display("vertex_dedup_indexer_unit test failed");
    end
    $finish;
  end

endmodule

// ----- vertex_dedup_indexer_unit.f -----
hw/rtl/vdi_pkg.sv
hw/rtl/vdi_in_if.sv
hw/rtl/vdi_out_if.sv
hw/rtl/vdi_cell.sv
hw/rtl/vertex_dedup_indexer_unit.sv
tb/tb_vertex_dedup_indexer_unit.sv
